>>> rtl/akwt_pkg.sv
package akwt_pkg;

	localparam int TABLE_ENTRIES = 16;
	localparam int MAX_RESULTS   = 16;
	localparam int IDX_W         = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam int CNT_W         = $clog2(MAX_RESULTS + 1);
	localparam int ADDR_W        = 64;
	localparam int THR_W         = 8;
	localparam int LIMIT_W       = 8;

	typedef enum logic [1:0] {
		OP_WAIT    = 2'd0,
		OP_WAKE    = 2'd1,
		OP_REQUEUE = 2'd2,
		OP_CLEAR   = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SINGLE,
		ST_SCAN,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic load;
		logic commit;
		logic step;
		logic finish;
	} dp_cmd_t;

	typedef struct packed {
		logic out_free;
		logic emit_needed;
		logic scan_end;
	} dp_stat_t;

endpackage

>>> rtl/akwt_ctrl.sv
module akwt_ctrl import akwt_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	input  logic     in_ready_op_single,
	output logic     in_ready,
	input  dp_stat_t stat,
	output dp_cmd_t  cmd
);

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = in_ready_op_single ? ST_SINGLE : ST_SCAN;
				end
			end
			ST_SINGLE: begin
				if (stat.out_free) begin
					cmd.commit = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			ST_SCAN: begin
				if (!(stat.emit_needed && !stat.out_free)) begin
					cmd.step = 1'b1;
					if (stat.scan_end) begin
						state_d = ST_FINISH;
					end
				end
			end
			ST_FINISH: begin
				if (stat.out_free) begin
					cmd.finish = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

>>> rtl/akwt_datapath.sv
module akwt_datapath import akwt_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [1:0]         operation,
	input  logic [ADDR_W-1:0]  address,
	input  logic [THR_W-1:0]   thread_id,
	input  logic [LIMIT_W-1:0] wake_limit,
	input  logic [ADDR_W-1:0]  new_address,
	input  dp_cmd_t            cmd,
	output dp_stat_t           stat,
	input  logic               out_ready,
	output logic               out_valid,
	output logic               status,
	output logic               woken_valid,
	output logic [THR_W-1:0]   woken_thread,
	output logic               last
);

	logic [TABLE_ENTRIES-1:0] entry_valid_q;
	logic [ADDR_W-1:0]        entry_addr_q [TABLE_ENTRIES];
	logic [THR_W-1:0]         entry_thr_q  [TABLE_ENTRIES];

	op_t               op_q;
	logic [ADDR_W-1:0] addr_q;
	logic [ADDR_W-1:0] new_addr_q;
	logic [THR_W-1:0]  thr_q;
	logic [CNT_W-1:0]  rem_q;
	logic [IDX_W-1:0]  idx_q;
	logic              pend_v_q;
	logic [THR_W-1:0]  pend_thr_q;

	logic              out_valid_q;
	logic              status_q;
	logic              woken_valid_q;
	logic [THR_W-1:0]  woken_thread_q;
	logic              last_q;

	logic             hit;
	logic             wake_hit;
	logic             full;
	logic [IDX_W-1:0] free_idx;

	assign hit      = entry_valid_q[idx_q] && (entry_addr_q[idx_q] == addr_q);
	assign wake_hit = hit && (rem_q != '0);
	assign full     = &entry_valid_q;

	always_comb begin
		free_idx = '0;
		for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
			if (!entry_valid_q[i]) begin
				free_idx = IDX_W'(i);
			end
		end
	end

	assign stat.out_free    = !out_valid_q || out_ready;
	assign stat.emit_needed = wake_hit && pend_v_q;
	assign stat.scan_end    = (idx_q == IDX_W'(TABLE_ENTRIES - 1));

	// operation registers and scan state
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q       <= op_t'(operation);
			addr_q     <= address;
			new_addr_q <= new_address;
			thr_q      <= thread_id;
			rem_q      <= (wake_limit >= LIMIT_W'(MAX_RESULTS)) ? CNT_W'(MAX_RESULTS)
			                                                     : CNT_W'(wake_limit);
			idx_q      <= '0;
		end else if (cmd.step) begin
			idx_q <= idx_q + 1'b1;
			if (wake_hit) begin
				rem_q      <= rem_q - 1'b1;
				pend_thr_q <= entry_thr_q[idx_q];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_v_q <= 1'b0;
		end else if (cmd.load) begin
			pend_v_q <= 1'b0;
		end else if (cmd.step && wake_hit) begin
			pend_v_q <= 1'b1;
		end
	end

	// table
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_valid_q <= '0;
		end else if (cmd.commit) begin
			if (op_q == OP_WAIT) begin
				if (!full) begin
					entry_valid_q[free_idx] <= 1'b1;
				end
			end else begin
				for (int i = 0; i < TABLE_ENTRIES; i++) begin
					if (entry_valid_q[i] && entry_thr_q[i] == thr_q) begin
						entry_valid_q[i] <= 1'b0;
					end
				end
			end
		end else if (cmd.step && wake_hit) begin
			entry_valid_q[idx_q] <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit && op_q == OP_WAIT && !full) begin
			entry_addr_q[free_idx] <= addr_q;
			entry_thr_q[free_idx]  <= thr_q;
		end else if (cmd.step && hit && !wake_hit && op_q == OP_REQUEUE) begin
			entry_addr_q[idx_q] <= new_addr_q;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.commit || cmd.finish || (cmd.step && wake_hit && pend_v_q)) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			status_q       <= (op_q == OP_WAIT) && full;
			woken_valid_q  <= 1'b0;
			woken_thread_q <= '0;
			last_q         <= 1'b1;
		end else if (cmd.finish) begin
			status_q       <= 1'b0;
			woken_valid_q  <= pend_v_q;
			woken_thread_q <= pend_v_q ? pend_thr_q : '0;
			last_q         <= 1'b1;
		end else if (cmd.step && wake_hit && pend_v_q) begin
			status_q       <= 1'b0;
			woken_valid_q  <= 1'b1;
			woken_thread_q <= pend_thr_q;
			last_q         <= 1'b0;
		end
	end

	assign out_valid    = out_valid_q;
	assign status       = status_q;
	assign woken_valid  = woken_valid_q;
	assign woken_thread = woken_thread_q;
	assign last         = last_q;

endmodule

>>> rtl/address_keyed_wait_table_core.sv
// Address-keyed wait table: a 16-entry table of waiting threads keyed by address.
// Input channel (in_valid/in_ready) takes one operation per beat: wait, wake,
// requeue or clear thread. Output channel (out_valid/out_ready) returns result
// beats; every operation ends with a beat that has last set.
// Wait and clear: one result beat, registered once the result register is free.
// Wake and requeue: one sequential pass over the table, one entry per cycle
// while no result beat is stalled, then a closing beat; a woken thread is held
// back until the next wake hit or the close so that last can be marked.
// One operation is in flight at a time; in_ready is high while idle, and the
// next operation is taken even while the final result beat still waits.
// When the receiver stalls, the scan holds on the entry that needs to emit
// until the result register frees up; nothing is dropped.
// Reset empties the table (all entries invalid) and clears the result valid flag.
module address_keyed_wait_table_core import akwt_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         operation,
	input  logic [ADDR_W-1:0]  address,
	input  logic [THR_W-1:0]   thread_id,
	input  logic [LIMIT_W-1:0] wake_limit,
	input  logic [ADDR_W-1:0]  new_address,
	output logic               out_valid,
	input  logic               out_ready,
	output logic               status,
	output logic               woken_valid,
	output logic [THR_W-1:0]   woken_thread,
	output logic               last
);

	dp_cmd_t  cmd;
	dp_stat_t stat;
	logic     op_single;

	assign op_single = (operation == OP_WAIT) || (operation == OP_CLEAR);

	akwt_ctrl u_ctrl (
		.clk                (clk),
		.arst_n             (arst_n),
		.in_valid           (in_valid),
		.in_ready_op_single (op_single),
		.in_ready           (in_ready),
		.stat               (stat),
		.cmd                (cmd)
	);

	akwt_datapath u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.operation    (operation),
		.address      (address),
		.thread_id    (thread_id),
		.wake_limit   (wake_limit),
		.new_address  (new_address),
		.cmd          (cmd),
		.stat         (stat),
		.out_ready    (out_ready),
		.out_valid    (out_valid),
		.status       (status),
		.woken_valid  (woken_valid),
		.woken_thread (woken_thread),
		.last         (last)
	);

endmodule
